// File: design/pec_pkg.sv
// ----------------------------------------------------------------------------
// Prefix expression converter package
// Shared types, character constants and the operand classifier.
// ----------------------------------------------------------------------------
package pec_pkg;

   // Character width of every input and output character.
   localparam int unsigned CHAR_W = 8;

   // Fixed output characters for the infix form.
   localparam logic [CHAR_W-1:0] OPEN_CHAR  = 8'h28;
   localparam logic [CHAR_W-1:0] CLOSE_CHAR = 8'h29;

   // Output form register encodings.
   localparam logic FORM_POSTFIX = 1'b0;
   localparam logic FORM_INFIX   = 1'b1;

   // A classified character as it travels from the front end to the back end.
   typedef struct packed {
      logic              is_operand;
      logic [CHAR_W-1:0] ch;
   } item_type;

   // Back-end sequencer states.
   typedef enum logic [1:0] {
      BK_IDLE,
      BK_READ,
      BK_WALK,
      BK_FLUSH
   } back_state_type;

   // Letters and digits are operands; every other byte is an operator.
   function automatic logic is_operand_char(input logic [CHAR_W-1:0] c);
      logic digit;
      logic upper;
      logic lower;
      digit = (c >= 8'h30) && (c <= 8'h39);
      upper = (c >= 8'h41) && (c <= 8'h5A);
      lower = (c >= 8'h61) && (c <= 8'h7A);
      return digit || upper || lower;
   endfunction

endpackage

// File: design/pec_front.sv
// ----------------------------------------------------------------------------
// Prefix expression converter front end
// Accepts input characters, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pec_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [pec_pkg::CHAR_W-1:0] req_in_char,
   output logic                   q_valid,
   output pec_pkg::item_type      q_item,
   input  logic                   q_pop
);
   import pec_pkg::*;

   localparam int unsigned QDEPTH = 2;

   item_type    slot_ff [QDEPTH];
   logic        wr_ptr_ff;
   logic        wr_ptr_in;
   logic        rd_ptr_ff;
   logic        rd_ptr_in;
   logic [1:0]  count_ff;
   logic [1:0]  count_in;
   logic        push;
   logic        pop;

   // The queue is full when both slots hold an item.
   assign req_stall = (count_ff == 2'(QDEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   // Pointer and count update.
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Classify the character as it enters the queue.
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff].is_operand <= is_operand_char(req_in_char);
         slot_ff[wr_ptr_ff].ch         <= req_in_char;
      end
   end

endmodule

// File: design/pec_back.sv
// ----------------------------------------------------------------------------
// Prefix expression converter back end
// Keeps the operator stack and walks it to emit postfix or infix text.
// ----------------------------------------------------------------------------
module pec_back #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   output_form,
   input  logic                   q_valid,
   input  pec_pkg::item_type      q_item,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [pec_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                   rsp_status,
   output logic                   rsp_expr_done,
   output logic                   rsp_last
);
   import pec_pkg::*;

   localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int unsigned FW = $clog2(STACK_DEPTH + 1);
   localparam int unsigned EW = CHAR_W + 1;

   back_state_type    state_ff;
   back_state_type    state_in;
   logic [FW-1:0]     fill_ff;
   logic [FW-1:0]     fill_in;
   logic [FW-1:0]     fill_m1;
   logic              pend_ff;
   logic              pend_in;
   logic [CHAR_W-1:0] pend_char_ff;
   logic [CHAR_W-1:0] pend_char_in;

   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [CHAR_W-1:0] rsp_char_ff;
   logic [CHAR_W-1:0] rsp_char_in;
   logic              rsp_status_ff;
   logic              rsp_status_in;
   logic              rsp_done_ff;
   logic              rsp_done_in;
   logic              rsp_last_ff;
   logic              rsp_last_in;

   logic [EW-1:0]     stack_mem [STACK_DEPTH];
   logic [EW-1:0]     rd_data_ff;
   logic              mem_rd_en;
   logic              mem_wr_en;
   logic [AW-1:0]     mem_wr_addr;
   logic [EW-1:0]     mem_wr_data;
   logic [AW-1:0]     top_addr;
   logic              stack_full;
   logic              can_emit;
   logic              top_mark;
   logic [CHAR_W-1:0] top_char;

   assign fill_m1    = fill_ff - FW'(1);
   assign top_addr   = fill_m1[AW-1:0];
   assign stack_full = (fill_ff == FW'(STACK_DEPTH));
   assign can_emit   = !rsp_valid_ff || !rsp_stall;
   assign top_mark   = rd_data_ff[CHAR_W];
   assign top_char   = rd_data_ff[CHAR_W-1:0];

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_char  = rsp_char_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_expr_done = rsp_done_ff;
   assign rsp_last      = rsp_last_ff;

   // Sequencer: next state, stack updates and the output register load.
   // An operand's result, and each popped result, is held as pending until
   // the next stack entry shows whether it is the last one of the item.
   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      pend_in       = pend_ff;
      pend_char_in  = pend_char_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_char_in   = rsp_char_ff;
      rsp_status_in = rsp_status_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_last_in   = rsp_last_ff;
      q_pop         = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = top_addr;
      mem_wr_data   = {1'b1, top_char};

      case (state_ff)
         BK_IDLE: begin
            if (q_valid && can_emit) begin
               q_pop = 1'b1;
               if (!q_item.is_operand) begin
                  if (stack_full) begin
                     // Overflow: drop the operator and clear the stack.
                     fill_in       = '0;
                     rsp_valid_in  = 1'b1;
                     rsp_char_in   = '0;
                     rsp_status_in = 1'b1;
                     rsp_done_in   = 1'b0;
                     rsp_last_in   = 1'b1;
                  end else begin
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = fill_ff[AW-1:0];
                     mem_wr_data = {1'b0, q_item.ch};
                     fill_in     = fill_ff + FW'(1);
                     if (output_form == FORM_INFIX) begin
                        rsp_valid_in  = 1'b1;
                        rsp_char_in   = OPEN_CHAR;
                        rsp_status_in = 1'b0;
                        rsp_done_in   = 1'b0;
                        rsp_last_in   = 1'b1;
                     end
                  end
               end else if (fill_ff == '0) begin
                  // A lone operand is a whole expression.
                  rsp_valid_in  = 1'b1;
                  rsp_char_in   = q_item.ch;
                  rsp_status_in = 1'b0;
                  rsp_done_in   = 1'b1;
                  rsp_last_in   = 1'b1;
               end else begin
                  pend_in      = 1'b1;
                  pend_char_in = q_item.ch;
                  state_in     = BK_READ;
               end
            end
         end

         BK_READ: begin
            mem_rd_en = 1'b1;
            state_in  = BK_WALK;
         end

         BK_WALK: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = 1'b0;
               rsp_done_in   = 1'b0;
               if (!pend_ff) begin
                  // Infix: the operator goes between its two operands.
                  mem_wr_en   = 1'b1;
                  rsp_char_in = top_char;
                  rsp_last_in = 1'b1;
                  state_in    = BK_IDLE;
               end else if (!top_mark) begin
                  rsp_char_in = pend_char_ff;
                  if (output_form == FORM_INFIX) begin
                     rsp_last_in = 1'b0;
                     pend_in     = 1'b0;
                  end else begin
                     mem_wr_en   = 1'b1;
                     rsp_last_in = 1'b1;
                     pend_in     = 1'b0;
                     state_in    = BK_IDLE;
                  end
               end else begin
                  // Both operands done: pop the operator.
                  rsp_char_in  = pend_char_ff;
                  rsp_last_in  = 1'b0;
                  pend_char_in = (output_form == FORM_INFIX) ? CLOSE_CHAR : top_char;
                  fill_in      = fill_m1;
                  state_in     = (fill_m1 == '0) ? BK_FLUSH : BK_READ;
               end
            end
         end

         BK_FLUSH: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_char_in   = pend_char_ff;
               rsp_status_in = 1'b0;
               rsp_done_in   = 1'b1;
               rsp_last_in   = 1'b1;
               pend_in       = 1'b0;
               state_in      = BK_IDLE;
            end
         end

         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pend_char_ff  <= pend_char_in;
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
      rsp_done_ff   <= rsp_done_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Operator stack memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         stack_mem[mem_wr_addr] <= mem_wr_data;
      end
      if (mem_rd_en) begin
         rd_data_ff <= stack_mem[top_addr];
      end
   end

endmodule

// File: design/prefix_expression_converter.sv
// ----------------------------------------------------------------------------
// Prefix expression converter
// Converts a prefix character stream into postfix or fully parenthesized
// infix text, one output character per transaction.
//
//   Channel  Ports                                   Direction
//   req      req_valid, req_stall, req_in_char       in
//   rsp      rsp_valid, rsp_stall, rsp_out_char,     out
//            rsp_status, rsp_expr_done, rsp_last
//   csr      csr_wr_en, csr_wr_data                  in
//
// An operator or a lone operand is handled in the back end's idle state
// alone. An operand that completes pending operators passes through the
// read and walk states for each stack entry it reaches (memory read, then
// evaluate), walks once more in infix form for the entry where the walk
// stops, and passes through the flush state when the stack empties.
// Reset clears the stack fill, the queue and the output form; stack memory
// contents are not cleared. An output stall holds the back end while the
// two-entry input queue keeps accepting transactions until it is full.
// ----------------------------------------------------------------------------
module prefix_expression_converter #(
   parameter int unsigned STACK_DEPTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [pec_pkg::CHAR_W-1:0] req_in_char,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [pec_pkg::CHAR_W-1:0] rsp_out_char,
   output logic                   rsp_status,
   output logic                   rsp_expr_done,
   output logic                   rsp_last,
   input  logic                   csr_wr_en,
   input  logic                   csr_wr_data
);
   import pec_pkg::*;

   logic     output_form_ff;
   logic     q_valid;
   item_type q_item;
   logic     q_pop;

   // Output form register.
   always_ff @(posedge clock) begin
      if (reset) begin
         output_form_ff <= FORM_POSTFIX;
      end else if (csr_wr_en) begin
         output_form_ff <= csr_wr_data;
      end
   end

   pec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_char (req_in_char),
      .q_valid     (q_valid),
      .q_item      (q_item),
      .q_pop       (q_pop)
   );

   pec_back #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .output_form   (output_form_ff),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_char  (rsp_out_char),
      .rsp_status    (rsp_status),
      .rsp_expr_done (rsp_expr_done),
      .rsp_last      (rsp_last)
   );

endmodule

// File: design/pec_checker.sv
// ----------------------------------------------------------------------------
// Prefix expression converter checker
// Port-level properties of the converter, bound to the top level.
// ----------------------------------------------------------------------------
module pec_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [pec_pkg::CHAR_W-1:0] req_in_char,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [pec_pkg::CHAR_W-1:0] rsp_out_char,
   input logic                   rsp_status,
   input logic                   rsp_expr_done,
   input logic                   rsp_last
);
   import pec_pkg::*;

   // A stalled input transaction holds its valid and payload.
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_in_char))
      else $error("stalled input changed");

   // A stalled result transaction holds its valid and payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_char)
         && $stable(rsp_status) && $stable(rsp_expr_done) && $stable(rsp_last))
      else $error("stalled result changed");

   // A completed expression always ends the results of its character.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_expr_done |-> rsp_last)
      else $error("expression done on a non-final result");

   // An overflow report is a single, final, zero-character result.
   a_overflow_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_last && !rsp_expr_done
         && (rsp_out_char == '0))
      else $error("malformed overflow result");

   // No result is offered right after reset.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind prefix_expression_converter pec_checker u_pec_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .req_in_char   (req_in_char),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_out_char  (rsp_out_char),
   .rsp_status    (rsp_status),
   .rsp_expr_done (rsp_expr_done),
   .rsp_last      (rsp_last)
);
